// File: rtl/brtq_pkg.sv
// Shared types and constants of the bucketed reset time queue.
// Used by brtq_div, brtq_cell and bucketed_reset_time_queue; no dependencies.
package brtq_pkg;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned ID_W     = 10;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned GRAN_W   = 16;
    localparam int unsigned STATUS_W = 2;
    // dividend of the bucket division: due time plus granule minus one, or the now time for poll
    localparam int unsigned DIVD_W   = TIME_W + 1;
    localparam int unsigned DCNT_W   = $clog2(DIVD_W);

    localparam logic [GRAN_W-1:0] GRANULE_RESET = 16'd64;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_POLL   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   object_id;
        logic [TIME_W-1:0] due_time;
        logic [TIME_W-1:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     due_object;
    } t_out_item;

    // one queue slot as held in a cell
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] bucket;
        logic [ID_W-1:0]   object;
    } t_entry;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_SCAN,
        CMD_INSERT,
        CMD_DROP,
        CMD_POP
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd         cmd;
        logic [TIME_W-1:0] key_bucket;
        logic [ID_W-1:0]   key_object;
    } t_cell_ctl;

endpackage

// File: rtl/brtq_div.sv
// Restoring divider, one quotient bit per cycle, for the bucket calculation.
// Depends on brtq_pkg for widths.
module brtq_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [brtq_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [brtq_pkg::GRAN_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [brtq_pkg::DIVD_W-1:0]  o_quotient
);

    logic                         r_busy;
    logic                         r_done;
    logic [brtq_pkg::DCNT_W-1:0]  r_cnt;
    logic [brtq_pkg::GRAN_W-1:0]  r_rem;
    logic [brtq_pkg::GRAN_W-1:0]  r_div;
    logic [brtq_pkg::DIVD_W-1:0]  r_quo;

    logic [brtq_pkg::GRAN_W:0]    w_shifted;
    logic                         w_ge;
    logic [brtq_pkg::GRAN_W-1:0]  n_rem;
    logic [brtq_pkg::DIVD_W-1:0]  n_quo;

    always_comb begin
        w_shifted = {r_rem, r_quo[brtq_pkg::DIVD_W-1]};
        w_ge      = (w_shifted >= {1'b0, r_div});
        n_rem     = w_ge ? brtq_pkg::GRAN_W'(w_shifted - {1'b0, r_div})
                         : w_shifted[brtq_pkg::GRAN_W-1:0];
        n_quo     = {r_quo[brtq_pkg::DIVD_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == brtq_pkg::DCNT_W'(brtq_pkg::DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/brtq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbours.
// Depends on brtq_pkg for the entry and control types.
module brtq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  brtq_pkg::t_cell_ctl  i_ctl,
    input  brtq_pkg::t_entry     i_left,
    input  logic                 i_left_keep,
    input  logic                 i_left_hit,
    input  brtq_pkg::t_entry     i_right,
    output brtq_pkg::t_entry     o_entry,
    output logic                 o_keep,
    output logic                 o_hit
);

    brtq_pkg::t_entry r_entry;
    brtq_pkg::t_entry n_entry;
    logic             r_hit;
    logic             w_match;

    // keep: this entry stays ahead of a new item with the key bucket
    assign o_keep  = r_entry.valid && (r_entry.bucket < i_ctl.key_bucket);
    assign w_match = r_entry.valid && (r_entry.bucket == i_ctl.key_bucket)
                     && (r_entry.object == i_ctl.key_object);
    // hit: a matching entry sits here or somewhere to the left
    assign o_hit   = r_hit || w_match;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.cmd)
            brtq_pkg::CMD_INSERT: begin
                if (!o_keep) begin
                    if (i_left_keep) begin
                        n_entry.valid  = 1'b1;
                        n_entry.bucket = i_ctl.key_bucket;
                        n_entry.object = i_ctl.key_object;
                    end else begin
                        n_entry = i_left;
                    end
                end
            end
            brtq_pkg::CMD_DROP: begin
                if (o_hit) begin
                    n_entry = i_right;
                end
            end
            brtq_pkg::CMD_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_hit         <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
            case (i_ctl.cmd)
                brtq_pkg::CMD_CLEAR: begin
                    r_hit <= 1'b0;
                end
                brtq_pkg::CMD_SCAN: begin
                    r_hit <= i_left_hit;
                end
                default: begin
                    r_hit <= r_hit;
                end
            endcase
        end
        r_entry.bucket <= n_entry.bucket;
        r_entry.object <= n_entry.object;
    end

    assign o_entry = r_entry;

endmodule

// File: rtl/bucketed_reset_time_queue.sv
// Bucketed reset time queue: a row of cells kept sorted by bucket; needs brtq_pkg,
// brtq_div and brtq_cell. An item settled at once (zero time, full, bad op) goes
// straight to the response; add and poll wait for the bucket divider, and remove
// then scans too, where a match flag walks the cell row one cell per cycle.
// One item at a time; a result waits in the response state while the output is held.
// Reset (synchronous, active low) empties the queue and sets the granule to 64.
module bucketed_reset_time_queue #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  brtq_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output brtq_pkg::t_out_item          o_out_item,
    input  logic                         i_cfg_wr_en,
    input  logic [brtq_pkg::GRAN_W-1:0]  i_cfg_wr_data
);

    localparam int unsigned SCNT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_APPLY,
        S_RESP
    } t_state;

    t_state                          r_state;
    logic [brtq_pkg::GRAN_W-1:0]     r_granule;
    logic [brtq_pkg::OP_W-1:0]       r_op;
    logic [brtq_pkg::ID_W-1:0]       r_id;
    logic [brtq_pkg::TIME_W-1:0]     r_key;
    logic [SCNT_W-1:0]               r_scan_cnt;
    brtq_pkg::t_out_item             r_res;
    brtq_pkg::t_out_item             r_out_item;
    logic                            r_out_valid;

    logic                            w_accept;
    logic [brtq_pkg::GRAN_W-1:0]     w_gran;
    logic                            w_div_start;
    logic [brtq_pkg::DIVD_W-1:0]     w_dividend;
    logic                            w_div_done;
    logic [brtq_pkg::DIVD_W-1:0]     w_quotient;
    brtq_pkg::t_cell_ctl             w_ctl;
    brtq_pkg::t_entry                w_ent [CAPACITY];
    logic [CAPACITY-1:0]             w_keep;
    logic [CAPACITY-1:0]             w_hit;
    logic [CAPACITY-1:0]             w_valid;
    logic [CAPACITY:0]               w_valid_p1;
    logic                            w_full;
    logic                            w_found;
    logic                            w_head_due;
    logic                            w_in_timed;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_gran     = (r_granule == '0) ? brtq_pkg::GRAN_W'(1) : r_granule;
    assign w_full     = w_valid[CAPACITY-1];
    assign w_found    = w_hit[CAPACITY-1];
    assign w_head_due = w_ent[0].valid && (w_ent[0].bucket <= r_key);
    assign w_in_timed = (i_in_item.op == brtq_pkg::OP_ADD)
                        || (i_in_item.op == brtq_pkg::OP_REMOVE);

    // start the divider unless the item settles at once
    always_comb begin
        w_div_start = 1'b0;
        if (w_accept) begin
            if (i_in_item.op == brtq_pkg::OP_POLL) begin
                w_div_start = 1'b1;
            end else if (w_in_timed && (i_in_item.due_time != '0)) begin
                w_div_start = !((i_in_item.op == brtq_pkg::OP_ADD) && w_full);
            end
        end
    end

    // ceil for add and remove, floor for poll
    assign w_dividend = (i_in_item.op == brtq_pkg::OP_POLL)
                        ? {1'b0, i_in_item.now_time}
                        : {1'b0, i_in_item.due_time}
                          + {{(brtq_pkg::DIVD_W - brtq_pkg::GRAN_W){1'b0}}, w_gran}
                          - {{(brtq_pkg::DIVD_W - 1){1'b0}}, 1'b1};

    brtq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_gran),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        w_ctl.cmd        = brtq_pkg::CMD_NONE;
        w_ctl.key_bucket = r_key;
        w_ctl.key_object = r_id;
        case (r_state)
            S_DIV: begin
                if (w_div_done && (r_op == brtq_pkg::OP_REMOVE)) begin
                    w_ctl.cmd = brtq_pkg::CMD_CLEAR;
                end
            end
            S_SCAN: begin
                w_ctl.cmd = brtq_pkg::CMD_SCAN;
            end
            S_APPLY: begin
                case (r_op)
                    brtq_pkg::OP_ADD: begin
                        w_ctl.cmd = brtq_pkg::CMD_INSERT;
                    end
                    brtq_pkg::OP_REMOVE: begin
                        w_ctl.cmd = w_found ? brtq_pkg::CMD_DROP : brtq_pkg::CMD_NONE;
                    end
                    brtq_pkg::OP_POLL: begin
                        w_ctl.cmd = w_head_due ? brtq_pkg::CMD_POP : brtq_pkg::CMD_NONE;
                    end
                    default: begin
                        w_ctl.cmd = brtq_pkg::CMD_NONE;
                    end
                endcase
            end
            default: begin
                w_ctl.cmd = brtq_pkg::CMD_NONE;
            end
        endcase
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        brtq_pkg::t_entry w_left;
        brtq_pkg::t_entry w_right;
        logic             w_left_keep;
        logic             w_left_hit;

        if (gi == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_keep = 1'b1;
            assign w_left_hit  = 1'b0;
        end else begin : g_body
            assign w_left      = w_ent[gi-1];
            assign w_left_keep = w_keep[gi-1];
            assign w_left_hit  = w_hit[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_next
            assign w_right = w_ent[gi+1];
        end

        brtq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_left_hit  (w_left_hit),
            .i_right     (w_right),
            .o_entry     (w_ent[gi]),
            .o_keep      (w_keep[gi]),
            .o_hit       (w_hit[gi])
        );

        assign w_valid[gi] = w_ent[gi].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_granule   <= brtq_pkg::GRANULE_RESET;
            r_out_valid <= 1'b0;
            r_scan_cnt  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_granule <= i_cfg_wr_data;
            end
            // a result loaded in the response state keeps valid high instead
            if (r_out_valid && i_out_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op             <= i_in_item.op;
                        r_id             <= i_in_item.object_id;
                        r_res.due_object <= '0;
                        if (w_div_start) begin
                            r_state <= S_DIV;
                        end else begin
                            if (!w_in_timed) begin
                                r_res.status <= brtq_pkg::ST_MISS;
                            end else if (i_in_item.due_time == '0) begin
                                r_res.status <= brtq_pkg::ST_ZERO;
                            end else begin
                                r_res.status <= brtq_pkg::ST_FULL;
                            end
                            r_state <= S_RESP;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_key <= w_quotient[brtq_pkg::TIME_W-1:0];
                        if (r_op == brtq_pkg::OP_REMOVE) begin
                            r_scan_cnt <= '0;
                            r_state    <= S_SCAN;
                        end else begin
                            r_state <= S_APPLY;
                        end
                    end
                end
                S_SCAN: begin
                    // let the match flag reach the last cell
                    r_scan_cnt <= r_scan_cnt + 1'b1;
                    if (r_scan_cnt == SCNT_W'(CAPACITY - 1)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    case (r_op)
                        brtq_pkg::OP_ADD: begin
                            r_res.status <= brtq_pkg::ST_DONE;
                        end
                        brtq_pkg::OP_REMOVE: begin
                            r_res.status <= w_found ? brtq_pkg::ST_DONE : brtq_pkg::ST_MISS;
                        end
                        default: begin
                            r_res.status <= w_head_due ? brtq_pkg::ST_DONE : brtq_pkg::ST_MISS;
                            if (w_head_due) begin
                                r_res.due_object <= w_ent[0].object;
                            end
                        end
                    endcase
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_item  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_valid_p1 = {1'b0, w_valid} + {{CAPACITY{1'b0}}, 1'b1};

    // the divider only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    // occupied cells always form a prefix of the row
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_valid_p1))
        else $error("occupied cells do not form a prefix");

    // an insert adds exactly one entry
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.cmd == brtq_pkg::CMD_INSERT)
        |=> ($countones(w_valid) == $past($countones(w_valid)) + 1))
        else $error("insert did not add one entry");

    // drop and pop remove exactly one entry
    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_ctl.cmd == brtq_pkg::CMD_DROP) || (w_ctl.cmd == brtq_pkg::CMD_POP))
        |=> ($countones(w_valid) + 1 == $past($countones(w_valid))))
        else $error("drop or pop did not remove one entry");

endmodule
